[rtl/core/dfpe_pkg.sv]
// ----------------------------------------------------------------------------
// dfpe_pkg
// Shared types and constants of the DShot frame pulse encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dfpe_pkg;

    localparam int THR_W       = 11;
    localparam int CMD_W       = 12;
    localparam int TICK_W      = 15;
    localparam int FRAME_W     = 16;
    localparam int CNT_W       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 15;

    localparam logic [THR_W-1:0]   THR_MAX = 11'd2047;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_THROTTLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH_TICKS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW_TICKS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW_TICKS  = 3'd4;

    // Reset values
    localparam logic [THR_W-1:0]  RST_MIN_THROTTLE    = 11'd50;
    localparam logic [TICK_W-1:0] RST_ONE_HIGH_TICKS  = 15'd190;
    localparam logic [TICK_W-1:0] RST_ONE_LOW_TICKS   = 15'd76;
    localparam logic [TICK_W-1:0] RST_ZERO_HIGH_TICKS = 15'd95;
    localparam logic [TICK_W-1:0] RST_ZERO_LOW_TICKS  = 15'd171;

    localparam logic [CNT_W-1:0] LAST_BIT_IDX = 4'd15;

    typedef struct packed {
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
    } t_tick_cfg;

endpackage

`default_nettype wire

[rtl/core/dfpe_cfg_regs.sv]
// ----------------------------------------------------------------------------
// dfpe_cfg_regs
// Configuration register file: throttle floor and pulse tick durations.
// ----------------------------------------------------------------------------
`default_nettype none

module dfpe_cfg_regs
    import dfpe_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_cfg_ready,
    output logic [THR_W-1:0]           o_min_throttle,
    output t_tick_cfg                  o_ticks
);

    logic [THR_W-1:0] r_min_throttle;
    t_tick_cfg        r_ticks;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_throttle    <= RST_MIN_THROTTLE;
            r_ticks.one_high  <= RST_ONE_HIGH_TICKS;
            r_ticks.one_low   <= RST_ONE_LOW_TICKS;
            r_ticks.zero_high <= RST_ZERO_HIGH_TICKS;
            r_ticks.zero_low  <= RST_ZERO_LOW_TICKS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MIN_THROTTLE:    r_min_throttle    <= i_cfg_data[THR_W-1:0];
                REG_ONE_HIGH_TICKS:  r_ticks.one_high  <= i_cfg_data[TICK_W-1:0];
                REG_ONE_LOW_TICKS:   r_ticks.one_low   <= i_cfg_data[TICK_W-1:0];
                REG_ZERO_HIGH_TICKS: r_ticks.zero_high <= i_cfg_data[TICK_W-1:0];
                REG_ZERO_LOW_TICKS:  r_ticks.zero_low  <= i_cfg_data[TICK_W-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    assign o_min_throttle = r_min_throttle;
    assign o_ticks        = r_ticks;

endmodule

`default_nettype wire

[rtl/core/dfpe_frame_build.sv]
// ----------------------------------------------------------------------------
// dfpe_frame_build
// Clamps the throttle, appends the telemetry bit and checksum, and holds
// the finished 16-bit frame until the serializer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dfpe_frame_build
    import dfpe_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [CMD_W-1:0]   i_throttle,
    input  wire logic [THR_W-1:0]   i_min_throttle,
    output logic                    o_frame_valid,
    output logic [FRAME_W-1:0]      o_frame,
    input  wire logic               i_frame_take
);

    logic [FRAME_W-1:0] r_frame;
    logic               r_full;
    logic [THR_W-1:0]   n_sat;
    logic [THR_W-1:0]   n_thr;
    logic [CMD_W-1:0]   n_word;
    logic [3:0]         n_sum;
    logic [FRAME_W-1:0] n_frame;

    always_comb begin
        n_sat   = (i_throttle > {1'b0, THR_MAX}) ? THR_MAX : i_throttle[THR_W-1:0];
        n_thr   = (n_sat < i_min_throttle) ? i_min_throttle : n_sat;
        n_word  = {n_thr, 1'b0};   // telemetry request stays clear
        n_sum   = n_word[3:0] ^ n_word[7:4] ^ n_word[11:8];
        n_frame = {n_word, n_sum};
    end

    // Free this slot in the same cycle the serializer takes it
    assign o_ready = !r_full || i_frame_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_full <= 1'b1;
        end else if (i_frame_take) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_frame <= n_frame;
        end
    end

    assign o_frame_valid = r_full;
    assign o_frame       = r_frame;

endmodule

`default_nettype wire

[rtl/core/dfpe_serializer.sv]
// ----------------------------------------------------------------------------
// dfpe_serializer
// Shifts a frame out MSB first, one bit beat per ready cycle, with its tick
// durations and a flag on the final bit.
// ----------------------------------------------------------------------------
`default_nettype none

module dfpe_serializer
    import dfpe_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_frame_valid,
    input  wire logic [FRAME_W-1:0] i_frame,
    output logic                    o_frame_take,
    input  wire t_tick_cfg          i_ticks,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_frame_bit,
    output logic [TICK_W-1:0]       o_high_ticks,
    output logic [TICK_W-1:0]       o_low_ticks,
    output logic                    o_last_bit
);

    logic [FRAME_W-1:0] r_shift;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               n_beat;
    logic               n_last;

    assign n_beat       = r_busy && i_ready;
    assign n_last       = (r_cnt == LAST_BIT_IDX);
    assign o_frame_take = i_frame_valid && (!r_busy || (n_beat && n_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (o_frame_take) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (n_beat) begin
            if (n_last) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_frame_take) begin
            r_shift <= i_frame;
        end else if (n_beat) begin
            r_shift <= {r_shift[FRAME_W-2:0], 1'b0};
        end
    end

    // Tick registers must only change while idle (not enforced here), so the payload holds under stall
    assign o_valid      = r_busy;
    assign o_frame_bit  = r_shift[FRAME_W-1];
    assign o_high_ticks = r_shift[FRAME_W-1] ? i_ticks.one_high : i_ticks.zero_high;
    assign o_low_ticks  = r_shift[FRAME_W-1] ? i_ticks.one_low  : i_ticks.zero_low;
    assign o_last_bit   = n_last;

`ifndef SYNTHESIS
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_take |=> (o_valid && r_cnt == '0))
        else $error("frame load did not restart the bit count");

    a_mid_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_beat && !n_last) |=> (o_valid && r_cnt == $past(r_cnt) + 1'b1))
        else $error("bit count did not advance after a mid-frame beat");

    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_beat && n_last && !i_frame_valid) |=> !o_valid)
        else $error("serializer stayed busy after the final bit");

    a_take_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_take |-> (!r_busy || (n_beat && n_last)))
        else $error("frame taken while a frame was still shifting");
`endif

endmodule

`default_nettype wire

[rtl/core/dshot_frame_pulse_encoder.sv]
// ----------------------------------------------------------------------------
// dshot_frame_pulse_encoder
// Turns a throttle command into the sixteen bit pulses of one DShot frame.
// ----------------------------------------------------------------------------
// Each accepted throttle beat yields sixteen output beats, one per cycle when
// the sink is ready; that rate is set by the bit serializer, which sends one
// frame bit per beat. The frame builder clamps and checksums a command in the
// cycle it is accepted and holds one finished frame ahead of the serializer,
// so the next command is taken while the current frame is still going out
// and frames follow each other with no gap. Configuration writes are always
// accepted and must only be issued while no frame is pending or in flight.
`default_nettype none

module dshot_frame_pulse_encoder
    import dfpe_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [CMD_W-1:0]      i_throttle,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_frame_bit,
    output logic [TICK_W-1:0]          o_high_ticks,
    output logic [TICK_W-1:0]          o_low_ticks,
    output logic                       o_last_bit,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [THR_W-1:0]   min_throttle;
    t_tick_cfg          ticks;
    logic               frame_valid;
    logic [FRAME_W-1:0] frame;
    logic               frame_take;

    dfpe_cfg_regs u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .o_min_throttle (min_throttle),
        .o_ticks        (ticks)
    );

    dfpe_frame_build u_build (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_throttle     (i_throttle),
        .i_min_throttle (min_throttle),
        .o_frame_valid  (frame_valid),
        .o_frame        (frame),
        .i_frame_take   (frame_take)
    );

    dfpe_serializer u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (frame_valid),
        .i_frame       (frame),
        .o_frame_take  (frame_take),
        .i_ticks       (ticks),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_frame_bit   (o_frame_bit),
        .o_high_ticks  (o_high_ticks),
        .o_low_ticks   (o_low_ticks),
        .o_last_bit    (o_last_bit)
    );

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DShot frame pulse encoder.
// ----------------------------------------------------------------------------
// Throttle commands and register writes go in over valid/ready channels. Each
// accepted command is turned into its sixteen expected pulse beats by a local
// frame encoder or typed in, and queued; every output beat is checked in order
// against that queue. A table of edge commands runs first at reset settings,
// followed by random traffic under several register settings and idle/stall
// mixes, including one long output hold-off that backs the encoder up.

module tb_top;
    import dfpe_pkg::*;

    localparam int CLK_HALF_NS     = 6;
    localparam int RST_CYCLES      = 12;
    // 440 frames x 16 beats, each beat behind a stall, plus the hold-off,
    // taken many times over
    localparam int CYCLE_LIMIT     = 300000;
    localparam int HOLD_LEN        = 400;
    localparam int DRAIN_CYCLES    = 40;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int MAX_REPORTS     = 10;
    localparam int CMD_MAX         = (1 << CMD_W) - 1;
    localparam int TICK_MAX        = (1 << TICK_W) - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = REG_ZERO_LOW_TICKS + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = '1;

    typedef struct packed {
        logic              bit_val;
        logic [TICK_W-1:0] hi_ticks;
        logic [TICK_W-1:0] lo_ticks;
        logic              last;
    } t_pulse;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic               typed;
        logic [FRAME_W-1:0] frame;
    } t_dir_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic [CMD_W-1:0]      i_throttle  = '0;
    logic                  i_ready     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_ready;
    logic                  o_valid;
    logic                  o_frame_bit;
    logic [TICK_W-1:0]     o_high_ticks;
    logic [TICK_W-1:0]     o_low_ticks;
    logic                  o_last_bit;
    logic                  o_cfg_ready;

    // shadow copy of the register file
    logic [THR_W-1:0]  min_thr = RST_MIN_THROTTLE;
    logic [TICK_W-1:0] one_hi  = RST_ONE_HIGH_TICKS;
    logic [TICK_W-1:0] one_lo  = RST_ONE_LOW_TICKS;
    logic [TICK_W-1:0] zero_hi = RST_ZERO_HIGH_TICKS;
    logic [TICK_W-1:0] zero_lo = RST_ZERO_LOW_TICKS;

    t_pulse pulse_q[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int hold_ack      = 0;
    int hold_left     = 0;
    int cycles        = 0;
    int n_errors      = 0;
    int n_cmds        = 0;
    int n_beats       = 0;
    int n_frames      = 0;
    int n_raised      = 0;
    int n_saturated   = 0;
    int n_settings    = 0;
    int n_backpress   = 0;

    // Edge commands at reset settings; frames typed in where obvious
    t_dir_row dir_rows [20] = '{
        '{12'd0,    1'b1, 16'h0642},  // below minimum
        '{12'd1,    1'b0, 16'h0000},
        '{12'd49,   1'b1, 16'h0642},
        '{12'd50,   1'b1, 16'h0642},  // exactly minimum
        '{12'd51,   1'b1, 16'h0660},
        '{12'd52,   1'b0, 16'h0000},
        '{12'd100,  1'b0, 16'h0000},
        '{12'd1024, 1'b0, 16'h0000},
        '{12'h555,  1'b0, 16'h0000},
        '{12'h2AA,  1'b0, 16'h0000},
        '{12'd2046, 1'b0, 16'h0000},
        '{12'd2047, 1'b1, 16'hFFEE},  // full scale
        '{12'd2048, 1'b1, 16'hFFEE},  // saturates
        '{12'd2049, 1'b1, 16'hFFEE},
        '{12'hAAA,  1'b1, 16'hFFEE},
        '{12'd4094, 1'b1, 16'hFFEE},
        '{12'd4095, 1'b1, 16'hFFEE},
        '{12'd1365, 1'b0, 16'h0000},
        '{12'd7,    1'b0, 16'h0000},
        '{12'd1500, 1'b0, 16'h0000}
    };

    dshot_frame_pulse_encoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_throttle   (i_throttle),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_frame_bit  (o_frame_bit),
        .o_high_ticks (o_high_ticks),
        .o_low_ticks  (o_low_ticks),
        .o_last_bit   (o_last_bit),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats still pending",
                     cycles, pulse_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Clamp, append telemetry bit and checksum nibble
    function automatic logic [FRAME_W-1:0] encode_frame(input logic [CMD_W-1:0] cmd);
        logic [THR_W-1:0] thr;
        logic [THR_W:0]   word;
        logic [3:0]       crc;
        if (cmd > THR_MAX)
            thr = THR_MAX;
        else
            thr = cmd[THR_W-1:0];
        if (thr < min_thr)
            thr = min_thr;
        word = {thr, 1'b0};
        crc  = word[3:0] ^ word[7:4] ^ word[11:8];
        return {word, crc};
    endfunction

    function automatic logic [CMD_W-1:0] rand_cmd();
        int lo;
        int hi;
        lo = (min_thr > 3) ? int'(min_thr) - 3 : 0;
        hi = int'(min_thr) + 3;
        case ($urandom_range(3))
            0:       rand_cmd = CMD_W'($urandom_range(CMD_MAX));
            1:       rand_cmd = CMD_W'($urandom_range(hi, lo));
            2:       rand_cmd = CMD_W'($urandom_range(int'(THR_MAX) + 4,
                                                      int'(THR_MAX) - 4));
            default: rand_cmd = CMD_W'($urandom_range(int'(THR_MAX)));
        endcase
    endfunction

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%0t ERROR: %s", $time, msg);
    endtask

    task automatic queue_pulses(input logic [FRAME_W-1:0] frame);
        t_pulse p;
        for (int k = 0; k < FRAME_W; k++) begin
            p.bit_val  = frame[FRAME_W-1-k];
            p.hi_ticks = p.bit_val ? one_hi : zero_hi;
            p.lo_ticks = p.bit_val ? one_lo : zero_lo;
            p.last     = (k == FRAME_W - 1);
            pulse_q.push_back(p);
        end
    endtask

    // Offer one command; valid stays up when the next one follows at once
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic typed,
                            input logic [FRAME_W-1:0] typed_frame);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_throttle <= cmd;
        do begin
            @(posedge i_clk);
            if (o_ready !== 1'b1)
                n_backpress++;
        end while (o_ready !== 1'b1);
        n_cmds++;
        if (cmd > THR_MAX)
            n_saturated++;
        else if (cmd[THR_W-1:0] < min_thr)
            n_raised++;
        queue_pulses(typed ? typed_frame : encode_frame(cmd));
    endtask

    task automatic settle_frames();
        i_valid <= 1'b0;
        while (pulse_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            REG_MIN_THROTTLE:    min_thr = data[THR_W-1:0];
            REG_ONE_HIGH_TICKS:  one_hi  = data[TICK_W-1:0];
            REG_ONE_LOW_TICKS:   one_lo  = data[TICK_W-1:0];
            REG_ZERO_HIGH_TICKS: zero_hi = data[TICK_W-1:0];
            REG_ZERO_LOW_TICKS:  zero_lo = data[TICK_W-1:0];
            default: ;
        endcase
    endtask

    // Write all registers, then poke an unused index that must be ignored
    task automatic set_regs(input logic [CFG_DATA_W-1:0] min_v,
                            input logic [CFG_DATA_W-1:0] oh, input logic [CFG_DATA_W-1:0] ol,
                            input logic [CFG_DATA_W-1:0] zh, input logic [CFG_DATA_W-1:0] zl);
        write_reg(REG_MIN_THROTTLE, min_v);
        write_reg(REG_ONE_HIGH_TICKS, oh);
        write_reg(REG_ONE_LOW_TICKS, ol);
        write_reg(REG_ZERO_HIGH_TICKS, zh);
        write_reg(REG_ZERO_LOW_TICKS, zl);
        write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_HI, CFG_IDX_SPARE_LO)),
                  CFG_DATA_W'($urandom_range(TICK_MAX)));
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic run_phase(input int send_pct, input int sink_pct, input logic hold);
        send_idle_pct = send_pct;
        stall_pct     = sink_pct;
        if (hold)
            hold_req++;
        repeat (ITEMS_PER_PHASE)
            send_cmd(rand_cmd(), 1'b0, '0);
        settle_frames();
    endtask

    // Output sink: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_beats
        t_pulse got;
        t_pulse want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            got = '{o_frame_bit, o_high_ticks, o_low_ticks, o_last_bit};
            n_beats++;
            if (pulse_q.size() == 0) begin
                note_error($sformatf("unexpected beat bit %0b high %0d low %0d last %0b",
                                     got.bit_val, got.hi_ticks, got.lo_ticks, got.last));
            end else begin
                want = pulse_q.pop_front();
                if (got.bit_val !== want.bit_val || got.hi_ticks !== want.hi_ticks ||
                    got.lo_ticks !== want.lo_ticks || got.last !== want.last)
                    note_error($sformatf(
                        "beat %0d: bit %0b/%0b high %0d/%0d low %0d/%0d last %0b/%0b (exp/act)",
                        n_beats, want.bit_val, got.bit_val, want.hi_ticks, got.hi_ticks,
                        want.lo_ticks, got.lo_ticks, want.last, got.last));
                else if (got.last)
                    n_frames++;
            end
        end
    end

    initial begin : stimulus
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r])
            send_cmd(dir_rows[r].cmd, dir_rows[r].typed, dir_rows[r].frame);
        settle_frames();

        // zero minimum, zero-length pulses
        set_regs('0, '0, '0, '0, '0);
        run_phase(0, 0, 1'b0);
        // wide minimum write keeps 2047, longest pulses
        set_regs('1, CFG_DATA_W'(TICK_MAX), CFG_DATA_W'(TICK_MAX),
                 CFG_DATA_W'(TICK_MAX), CFG_DATA_W'(TICK_MAX));
        run_phase(67, 0, 1'b0);
        set_regs(15'h4321, CFG_DATA_W'($urandom_range(TICK_MAX)),
                 CFG_DATA_W'($urandom_range(TICK_MAX)),
                 CFG_DATA_W'($urandom_range(TICK_MAX)),
                 CFG_DATA_W'($urandom_range(TICK_MAX)));
        run_phase(0, 67, 1'b0);
        set_regs(CFG_DATA_W'($urandom_range(int'(THR_MAX))),
                 CFG_DATA_W'($urandom_range(TICK_MAX)),
                 CFG_DATA_W'($urandom_range(TICK_MAX)),
                 CFG_DATA_W'($urandom_range(TICK_MAX)),
                 CFG_DATA_W'($urandom_range(TICK_MAX)));
        run_phase(28, 28, 1'b0);
        // sink holds off while commands keep coming: encoder must back up
        set_regs(CFG_DATA_W'($urandom_range(int'(THR_MAX))),
                 CFG_DATA_W'($urandom_range(TICK_MAX)),
                 CFG_DATA_W'($urandom_range(TICK_MAX)),
                 CFG_DATA_W'($urandom_range(TICK_MAX)),
                 CFG_DATA_W'($urandom_range(TICK_MAX)));
        run_phase(0, 0, 1'b1);
        set_regs(CFG_DATA_W'(RST_MIN_THROTTLE), RST_ONE_HIGH_TICKS, RST_ONE_LOW_TICKS,
                 RST_ZERO_HIGH_TICKS, RST_ZERO_LOW_TICKS);
        run_phase(28, 28, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d throttle commands (%0d raised to minimum, %0d saturated) over %0d settings",
                 n_cmds, n_raised, n_saturated, n_settings + 1);
        $display("Checked %0d pulse beats in %0d frames; input stalled %0d cycles, %0d errors",
                 n_beats, n_frames, n_backpress, n_errors);
        if (n_errors == 0 && pulse_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
